[src/tilt_compensated_compass_assert.svh]
// ----------------------------------------------------------------------------
// Tilt-compensated compass assertion macros
// Clocked assertion macros used by the compass top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_COMPASS_ASSERT_SVH
`define TILT_COMPENSATED_COMPASS_ASSERT_SVH

`ifndef ASSERT_OFF

`define TCC_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("compass assertion failed");

`define TCC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("compass assertion failed");

`define TCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("compass assertion failed");

`else

`define TCC_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TCC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define TCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[src/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt-compensated compass package
// Widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam int SAMPLE_BITS_DEFAULT   = 16;
   localparam int ANGLE_BITS_DEFAULT    = 16;
   localparam int CORDIC_STAGES_DEFAULT = 16;

   localparam int DATA_WIDTH  = 64;
   localparam int ZW          = 34;
   localparam int TRIG_WIDTH  = 34;
   localparam int TRIG_FRAC   = 28;
   localparam int GAIN_SHIFT  = 30;

   localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
   localparam logic [29:0] INV_GAIN_Q28 = 30'd163008219;
   localparam logic [30:0] QUARTER_TURN = 31'd1073741824;

   function automatic logic [31:0] atan_entry(input int unsigned idx);
      logic [31:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         24: v = 32'd41;
         25: v = 32'd20;
         26: v = 32'd10;
         27: v = 32'd5;
         28: v = 32'd3;
         29: v = 32'd1;
         30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

[src/tcc_vector.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// Quadrant fold followed by one register stage per CORDIC iteration.
// ----------------------------------------------------------------------------
module tcc_vector #(
   parameter int STAGES    = tcc_pkg::CORDIC_STAGES_DEFAULT,
   parameter int SIDE_BITS = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [tcc_pkg::DATA_WIDTH-1:0]   in_x,
   input  logic signed [tcc_pkg::DATA_WIDTH-1:0]   in_y,
   input  logic        [SIDE_BITS-1:0]             in_side,
   output logic                                    out_valid,
   output logic signed [tcc_pkg::DATA_WIDTH-1:0]   out_x,
   output logic signed [tcc_pkg::ZW-1:0]           out_z,
   output logic        [SIDE_BITS-1:0]             out_side
);
   localparam int DW = tcc_pkg::DATA_WIDTH;
   localparam int ZW = tcc_pkg::ZW;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(tcc_pkg::QUARTER_TURN);

   logic                 valid_ff [0:STAGES];
   logic signed [DW-1:0] x_ff     [0:STAGES];
   logic signed [DW-1:0] y_ff     [0:STAGES];
   logic signed [ZW-1:0] z_ff     [0:STAGES];
   logic [SIDE_BITS-1:0] side_ff  [0:STAGES];

   logic signed [DW-1:0] x_in;
   logic signed [DW-1:0] y_in;
   logic signed [ZW-1:0] z_in;

   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = in_y;
            y_in = -in_x;
            z_in = QUARTER;
         end else begin
            x_in = -in_y;
            y_in = in_x;
            z_in = -QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = ZW'(tcc_pkg::atan_entry(i));
      logic signed [DW-1:0] x_nx;
      logic signed [DW-1:0] y_nx;
      logic signed [ZW-1:0] z_nx;

      always_comb begin
         if (y_ff[i] >= 0) begin
            x_nx = x_ff[i] + (y_ff[i] >>> i);
            y_nx = y_ff[i] - (x_ff[i] >>> i);
            z_nx = z_ff[i] + ATAN;
         end else begin
            x_nx = x_ff[i] - (y_ff[i] >>> i);
            y_nx = y_ff[i] + (x_ff[i] >>> i);
            z_nx = z_ff[i] - ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_nx;
            y_ff[i+1]    <= y_nx;
            z_ff[i+1]    <= z_nx;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_x     = x_ff[STAGES];
   assign out_z     = z_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

[src/tcc_rotate.sv]
// ----------------------------------------------------------------------------
// Rotation CORDIC pipeline
// Produces cosine and sine in Q28 of a binary angle, one stage per iteration.
// ----------------------------------------------------------------------------
module tcc_rotate #(
   parameter int STAGES    = tcc_pkg::CORDIC_STAGES_DEFAULT,
   parameter int SIDE_BITS = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [tcc_pkg::ZW-1:0]           in_z,
   input  logic        [SIDE_BITS-1:0]             in_side,
   output logic                                    out_valid,
   output logic signed [tcc_pkg::TRIG_WIDTH-1:0]   out_c,
   output logic signed [tcc_pkg::TRIG_WIDTH-1:0]   out_s,
   output logic        [SIDE_BITS-1:0]             out_side
);
   localparam int TW = tcc_pkg::TRIG_WIDTH;
   localparam int ZW = tcc_pkg::ZW;
   localparam logic signed [TW-1:0] X_START = TW'(tcc_pkg::INV_GAIN_Q28);

   logic                 valid_ff [0:STAGES];
   logic signed [TW-1:0] x_ff     [0:STAGES];
   logic signed [TW-1:0] y_ff     [0:STAGES];
   logic signed [ZW-1:0] z_ff     [0:STAGES];
   logic [SIDE_BITS-1:0] side_ff  [0:STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= X_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= in_z;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = ZW'(tcc_pkg::atan_entry(i));
      logic signed [TW-1:0] x_nx;
      logic signed [TW-1:0] y_nx;
      logic signed [ZW-1:0] z_nx;

      always_comb begin
         if (z_ff[i] >= 0) begin
            x_nx = x_ff[i] - (y_ff[i] >>> i);
            y_nx = y_ff[i] + (x_ff[i] >>> i);
            z_nx = z_ff[i] - ATAN;
         end else begin
            x_nx = x_ff[i] + (y_ff[i] >>> i);
            y_nx = y_ff[i] - (x_ff[i] >>> i);
            z_nx = z_ff[i] + ATAN;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]    <= x_nx;
            y_ff[i+1]    <= y_nx;
            z_ff[i+1]    <= z_nx;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_c     = x_ff[STAGES];
   assign out_s     = y_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

[src/tcc_project.sv]
// ----------------------------------------------------------------------------
// Magnetometer projection
// Three stages: trig products, magnetometer products, then Xh and -Yh sums.
// ----------------------------------------------------------------------------
module tcc_project #(
   parameter int SAMPLE_BITS = tcc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int SIDE_BITS   = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [tcc_pkg::TRIG_WIDTH-1:0]   in_ca,
   input  logic signed [tcc_pkg::TRIG_WIDTH-1:0]   in_sa,
   input  logic signed [tcc_pkg::TRIG_WIDTH-1:0]   in_cb,
   input  logic signed [tcc_pkg::TRIG_WIDTH-1:0]   in_sb,
   input  logic signed [SAMPLE_BITS-1:0]           in_mx,
   input  logic signed [SAMPLE_BITS-1:0]           in_my,
   input  logic signed [SAMPLE_BITS-1:0]           in_mz,
   input  logic        [SIDE_BITS-1:0]             in_side,
   output logic                                    out_valid,
   output logic signed [tcc_pkg::DATA_WIDTH-1:0]   out_xh,
   output logic signed [tcc_pkg::DATA_WIDTH-1:0]   out_nyh,
   output logic        [SIDE_BITS-1:0]             out_side
);
   localparam int TW = tcc_pkg::TRIG_WIDTH;
   localparam int DW = tcc_pkg::DATA_WIDTH;
   localparam int MW = SAMPLE_BITS + TW;

   logic [2:0] valid_ff;

   logic signed [2*TW-1:0] sbsa_full;
   logic signed [2*TW-1:0] sbca_full;
   logic signed [TW-1:0]   sbsa_ff, sbca_ff, ca_ff, sa_ff, cb_ff;
   logic signed [SAMPLE_BITS-1:0] mx_ff, my_ff, mz_ff;
   logic [SIDE_BITS-1:0]   side1_ff, side2_ff, side3_ff;

   logic signed [MW-1:0] p_mxcb, p_my_sbsa, p_mz_sbca, p_myca, p_mzsa;
   logic signed [DW-1:0] mxcb_ff, mysbsa_ff, mzsbca_ff, myca_ff, mzsa_ff;
   logic signed [DW-1:0] xh_ff, nyh_ff;

   assign sbsa_full = in_sb * in_sa;
   assign sbca_full = in_sb * in_ca;

   assign p_mxcb    = MW'(mx_ff) * MW'(cb_ff);
   assign p_my_sbsa = MW'(my_ff) * MW'(sbsa_ff);
   assign p_mz_sbca = MW'(mz_ff) * MW'(sbca_ff);
   assign p_myca    = MW'(my_ff) * MW'(ca_ff);
   assign p_mzsa    = MW'(mz_ff) * MW'(sa_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sbsa_ff   <= TW'(sbsa_full >>> tcc_pkg::TRIG_FRAC);
         sbca_ff   <= TW'(sbca_full >>> tcc_pkg::TRIG_FRAC);
         ca_ff     <= in_ca;
         sa_ff     <= in_sa;
         cb_ff     <= in_cb;
         mx_ff     <= in_mx;
         my_ff     <= in_my;
         mz_ff     <= in_mz;
         side1_ff  <= in_side;

         mxcb_ff   <= DW'(p_mxcb);
         mysbsa_ff <= DW'(p_my_sbsa);
         mzsbca_ff <= DW'(p_mz_sbca);
         myca_ff   <= DW'(p_myca);
         mzsa_ff   <= DW'(p_mzsa);
         side2_ff  <= side1_ff;

         xh_ff     <= mxcb_ff + mysbsa_ff + mzsbca_ff;
         nyh_ff    <= -(myca_ff + mzsa_ff);
         side3_ff  <= side2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_xh    = xh_ff;
   assign out_nyh   = nyh_ff;
   assign out_side  = side3_ff;

endmodule

[src/tilt_compensated_compass.sv]
// ----------------------------------------------------------------------------
// Tilt-compensated compass
// Pitch, roll and tilt-compensated heading from one accelerometer and
// magnetometer sample, computed by a fully pipelined CORDIC datapath.
//
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   accel x/y/z, mag x/y/z, ok flags
// rsp_      out        rsp_valid/rsp_stall   pitch, roll, heading, degenerate
//
// One word is accepted every cycle while req_stall is low; each word passes
// through the four CORDIC pipelines in series (tilt magnitude, tilt angle,
// sine and cosine, heading).
// A word with either ok flag clear is dropped at the input and yields no word.
// Reset is synchronous and clears all valid bits.
// The output register has a one-word skid stage; req_stall is the skid
// stage's full flag, so it is a registered signal.
// ----------------------------------------------------------------------------
`include "tilt_compensated_compass_assert.svh"

module tilt_compensated_compass #(
   parameter int SAMPLE_BITS   = tcc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int ANGLE_BITS    = tcc_pkg::ANGLE_BITS_DEFAULT,
   parameter int CORDIC_STAGES = tcc_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic signed [SAMPLE_BITS-1:0] req_mag_x,
   input  logic signed [SAMPLE_BITS-1:0] req_mag_y,
   input  logic signed [SAMPLE_BITS-1:0] req_mag_z,
   input  logic                          req_accel_ok,
   input  logic                          req_mag_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_BITS-1:0]  rsp_pitch_angle,
   output logic signed [ANGLE_BITS-1:0]  rsp_roll_angle,
   output logic signed [ANGLE_BITS-1:0]  rsp_heading_angle,
   output logic                          rsp_degenerate
);
   localparam int DW = tcc_pkg::DATA_WIDTH;
   localparam int ZW = tcc_pkg::ZW;
   localparam int TW = tcc_pkg::TRIG_WIDTH;
   localparam int SB = SAMPLE_BITS;
   localparam int AB = ANGLE_BITS;
   localparam int N  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int PRESHIFT  = 58 - SAMPLE_BITS;
   localparam int OUT_SHIFT = 32 - ANGLE_BITS;
   localparam logic signed [ZW:0] ROUND = ((ZW+1)'(1) << OUT_SHIFT) >> 1;
   localparam int GS = tcc_pkg::GAIN_SHIFT;

   localparam int SIDE_A = DW + 3*SB + 1;
   localparam int SIDE_C = SB + 1;
   localparam int SIDE_D = 2*SB;
   localparam int SIDE_RA = SB + 1 + ZW;
   localparam int SIDE_RB = 2*SB + ZW;
   localparam int SIDE_P = 2*ZW + 1;
   localparam int SIDE_H = 2*ZW + 2;

   function automatic logic [AB-1:0] round_angle(input logic signed [ZW-1:0] z);
      logic signed [ZW:0] r;
      r = (ZW+1)'(z) + ROUND;
      return AB'(r >>> OUT_SHIFT);
   endfunction

   logic en;
   logic accept;
   logic skid_valid_ff, skid_valid_in;

   // Input register
   logic                 v0_ff;
   logic signed [DW-1:0] ax0_ff, ay0_ff, az0_ff;
   logic signed [SB-1:0] mx0_ff, my0_ff, mz0_ff;
   logic                 dg0_ff;
   logic                 dg0_in;

   assign en     = !skid_valid_ff;
   assign accept = req_valid && !req_stall;
   assign dg0_in = (req_accel_x == '0 && req_accel_y == '0 && req_accel_z == '0) ||
                   (req_mag_x == '0 && req_mag_y == '0 && req_mag_z == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= accept && req_accel_ok && req_mag_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax0_ff <= DW'(req_accel_x) <<< PRESHIFT;
         ay0_ff <= DW'(req_accel_y) <<< PRESHIFT;
         az0_ff <= DW'(req_accel_z) <<< PRESHIFT;
         mx0_ff <= req_mag_x;
         my0_ff <= req_mag_y;
         mz0_ff <= req_mag_z;
         dg0_ff <= dg0_in;
      end
   end

   // Tilt magnitudes
   logic                 va;
   logic signed [DW-1:0] mag_a, mag_b;
   logic signed [ZW-1:0] za_unused, zb_unused;
   logic [SIDE_A-1:0]    side_a;
   logic signed [DW-1:0] ay_a;
   logic                 vb_unused;

   tcc_vector #(.STAGES(N), .SIDE_BITS(SIDE_A)) u_vec_a (
      .clock(clock), .reset(reset), .en(en), .in_valid(v0_ff),
      .in_x(az0_ff), .in_y(ay0_ff),
      .in_side({ax0_ff, mx0_ff, my0_ff, mz0_ff, dg0_ff}),
      .out_valid(va), .out_x(mag_a), .out_z(za_unused), .out_side(side_a)
   );

   tcc_vector #(.STAGES(N), .SIDE_BITS(DW)) u_vec_b (
      .clock(clock), .reset(reset), .en(en), .in_valid(v0_ff),
      .in_x(az0_ff), .in_y(ax0_ff), .in_side(ay0_ff),
      .out_valid(vb_unused), .out_x(mag_b), .out_z(zb_unused), .out_side(ay_a)
   );

   // Gain removal, two stages
   logic [GS-1:0]        inv_gain;
   logic [1:0]           vu_ff;
   logic [DW-1:0]        pha_ff, pla_ff, phb_ff, plb_ff;
   logic signed [DW-1:0] syz_ff, sxz_ff;
   logic [SIDE_A-1:0]    side_u1_ff, side_u2_ff;
   logic signed [DW-1:0] ay_u1_ff, ay_u2_ff;
   logic signed [DW-1:0] ax_u;
   logic signed [SB-1:0] mx_u, my_u, mz_u;
   logic                 dg_u;

   assign inv_gain = tcc_pkg::INV_GAIN_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         vu_ff <= '0;
      end else if (en) begin
         vu_ff <= {vu_ff[0], va};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pha_ff     <= {{GS{1'b0}}, mag_a[DW-1:GS]} * {{(DW-GS){1'b0}}, inv_gain};
         pla_ff     <= {{(DW-GS){1'b0}}, mag_a[GS-1:0]} * {{(DW-GS){1'b0}}, inv_gain};
         phb_ff     <= {{GS{1'b0}}, mag_b[DW-1:GS]} * {{(DW-GS){1'b0}}, inv_gain};
         plb_ff     <= {{(DW-GS){1'b0}}, mag_b[GS-1:0]} * {{(DW-GS){1'b0}}, inv_gain};
         side_u1_ff <= side_a;
         ay_u1_ff   <= ay_a;
         syz_ff     <= signed'(pha_ff + {{GS{1'b0}}, pla_ff[DW-1:GS]});
         sxz_ff     <= signed'(phb_ff + {{GS{1'b0}}, plb_ff[DW-1:GS]});
         side_u2_ff <= side_u1_ff;
         ay_u2_ff   <= ay_u1_ff;
      end
   end

   assign {ax_u, mx_u, my_u, mz_u, dg_u} = side_u2_ff;

   // Tilt angles
   logic                 vc;
   logic signed [ZW-1:0] alpha, beta;
   logic signed [DW-1:0] magc_unused, magd_unused;
   logic [SIDE_C-1:0]    side_c;
   logic [SIDE_D-1:0]    side_d;
   logic                 vd_unused;

   tcc_vector #(.STAGES(N), .SIDE_BITS(SIDE_C)) u_vec_c (
      .clock(clock), .reset(reset), .en(en), .in_valid(vu_ff[1]),
      .in_x(syz_ff), .in_y(ax_u), .in_side({mx_u, dg_u}),
      .out_valid(vc), .out_x(magc_unused), .out_z(alpha), .out_side(side_c)
   );

   tcc_vector #(.STAGES(N), .SIDE_BITS(SIDE_D)) u_vec_d (
      .clock(clock), .reset(reset), .en(en), .in_valid(vu_ff[1]),
      .in_x(sxz_ff), .in_y(ay_u2_ff), .in_side({my_u, mz_u}),
      .out_valid(vd_unused), .out_x(magd_unused), .out_z(beta), .out_side(side_d)
   );

   // Sine and cosine
   logic                 vr;
   logic signed [TW-1:0] ca, sa, cb, sb;
   logic [SIDE_RA-1:0]   side_ra;
   logic [SIDE_RB-1:0]   side_rb;
   logic                 vrb_unused;
   logic signed [SB-1:0] mx_r, my_r, mz_r;
   logic                 dg_r;
   logic signed [ZW-1:0] alpha_r, beta_r;

   tcc_rotate #(.STAGES(N), .SIDE_BITS(SIDE_RA)) u_rot_a (
      .clock(clock), .reset(reset), .en(en), .in_valid(vc),
      .in_z(alpha), .in_side({side_c, alpha}),
      .out_valid(vr), .out_c(ca), .out_s(sa), .out_side(side_ra)
   );

   tcc_rotate #(.STAGES(N), .SIDE_BITS(SIDE_RB)) u_rot_b (
      .clock(clock), .reset(reset), .en(en), .in_valid(vc),
      .in_z(beta), .in_side({side_d, beta}),
      .out_valid(vrb_unused), .out_c(cb), .out_s(sb), .out_side(side_rb)
   );

   assign {mx_r, dg_r, alpha_r} = side_ra;
   assign {my_r, mz_r, beta_r}  = side_rb;

   // Projection onto the horizontal plane
   logic                 vp;
   logic signed [DW-1:0] xh, nyh;
   logic [SIDE_P-1:0]    side_p;
   logic                 level;

   tcc_project #(.SAMPLE_BITS(SB), .SIDE_BITS(SIDE_P)) u_project (
      .clock(clock), .reset(reset), .en(en), .in_valid(vr),
      .in_ca(ca), .in_sa(sa), .in_cb(cb), .in_sb(sb),
      .in_mx(mx_r), .in_my(my_r), .in_mz(mz_r),
      .in_side({alpha_r, beta_r, dg_r}),
      .out_valid(vp), .out_xh(xh), .out_nyh(nyh), .out_side(side_p)
   );

   assign level = (xh == '0) && (nyh == '0);

   // Heading
   logic                 vh;
   logic signed [DW-1:0] magh_unused;
   logic signed [ZW-1:0] heading;
   logic [SIDE_H-1:0]    side_h;
   logic signed [ZW-1:0] alpha_h, beta_h;
   logic                 dg_h, level_h;

   tcc_vector #(.STAGES(N), .SIDE_BITS(SIDE_H)) u_vec_h (
      .clock(clock), .reset(reset), .en(en), .in_valid(vp),
      .in_x(xh), .in_y(nyh), .in_side({side_p, level}),
      .out_valid(vh), .out_x(magh_unused), .out_z(heading), .out_side(side_h)
   );

   assign {alpha_h, beta_h, dg_h, level_h} = side_h;

   // Output register and skid stage
   logic [AB-1:0] pitch_in, roll_in, head_in;
   logic          take;
   logic          load_out, load_skid;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0] pitch_ff, roll_ff, head_ff;
   logic          dg_ff;
   logic [AB-1:0] skid_pitch_ff, skid_roll_ff, skid_head_ff;
   logic          skid_dg_ff;
   logic          angles_zero;

   always_comb begin
      pitch_in = '0;
      roll_in  = '0;
      head_in  = '0;
      if (!dg_h) begin
         pitch_in = round_angle(alpha_h);
         roll_in  = round_angle(beta_h);
         if (!level_h) begin
            head_in = round_angle(heading);
         end
      end
   end

   assign take      = rsp_valid_ff && !rsp_stall;
   assign load_out  = en && vh && (!rsp_valid_ff || take);
   assign load_skid = en && vh && rsp_valid_ff && !take;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (load_skid) begin
         skid_valid_in = 1'b1;
      end else if (take) begin
         rsp_valid_in  = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
         head_ff  <= head_in;
         dg_ff    <= dg_h;
      end else if (take && skid_valid_ff) begin
         pitch_ff <= skid_pitch_ff;
         roll_ff  <= skid_roll_ff;
         head_ff  <= skid_head_ff;
         dg_ff    <= skid_dg_ff;
      end
      if (load_skid) begin
         skid_pitch_ff <= pitch_in;
         skid_roll_ff  <= roll_in;
         skid_head_ff  <= head_in;
         skid_dg_ff    <= dg_h;
      end
   end

   assign angles_zero       = (pitch_ff == '0) && (roll_ff == '0) && (head_ff == '0);
   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pitch_angle   = signed'(pitch_ff);
   assign rsp_roll_angle    = signed'(roll_ff);
   assign rsp_heading_angle = signed'(head_ff);
   assign rsp_degenerate    = dg_ff;

   `TCC_ASSERT_IMPLIES(a_skid_needs_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `TCC_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && take, rsp_valid_ff && !skid_valid_ff)
   `TCC_ASSERT_IMPLIES(a_degenerate_zero, clock, reset, rsp_valid_ff && dg_ff, angles_zero)
   `TCC_ASSERT_NEXT(a_frozen_input, clock, reset, skid_valid_ff, $stable(v0_ff))

endmodule

[test/tilt_compensated_compass_tb.sv]
// ----------------------------------------------------------------------------
// Tilt-compensated compass testbench
// Drives IMU samples into the compass, predicts pitch, roll, heading and the
// degenerate flag with a bit-exact CORDIC model of its own, and checks every
// returned word in order under random input bursts and output stalls.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES      = tcc_pkg::CORDIC_STAGES_DEFAULT;
   localparam int LATENCY     = 4 * STAGES + 11;
   localparam int PRESHIFT    = 58 - 16;
   localparam int EXPECT_DEPTH = 256;
   localparam longint QUARTER = 64'sd1073741824;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint GAIN_Q28 = 64'sd163008219;

   typedef struct packed {
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [15:0] heading;
      logic        degenerate;
   } angles_type;

   typedef struct packed {
      logic [15:0] ax, ay, az, mx, my, mz;
      logic        accel_ok, mag_ok;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [15:0] req_mag_x = '0, req_mag_y = '0, req_mag_z = '0;
   logic req_accel_ok = 1'b0, req_mag_ok = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_pitch_angle, rsp_roll_angle, rsp_heading_angle;
   logic rsp_degenerate;

   angles_type expected_angles[EXPECT_DEPTH];
   int expected_head = 0;
   int expected_tail = 0;
   int expected_count = 0;
   int errors = 0;
   int burst_left = 0;
   int hold_cycles = 0;
   int stall_phase = 0;
   int stall_mode = 0;

   longint arctan_steps[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   tilt_compensated_compass u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void store_expected(input angles_type a);
      if (expected_count == EXPECT_DEPTH) begin
         $display("%0t: expectation buffer overflow", $realtime);
         errors++;
         return;
      end
      expected_angles[expected_tail] = a;
      expected_tail = (expected_tail + 1) % EXPECT_DEPTH;
      expected_count++;
   endfunction

   function automatic angles_type fetch_expected();
      angles_type a;
      a = expected_angles[expected_head];
      expected_head = (expected_head + 1) % EXPECT_DEPTH;
      expected_count--;
      return a;
   endfunction

   function automatic longint vector_angle(input longint x0, input longint y0,
                                           output longint magnitude);
      longint x, y, z, t, dx, dy;
      x = x0;
      y = y0;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER;
         end
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += arctan_steps[i];
         end else begin
            x -= dx; y += dy; z -= arctan_steps[i];
         end
      end
      magnitude = x;
      return z;
   endfunction

   function automatic void sin_cos(input longint angle, output longint c,
                                   output longint s);
      longint x, y, z, dx, dy;
      x = GAIN_Q28;
      y = 0;
      z = angle;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_steps[i];
         end else begin
            x += dx; y -= dy; z += arctan_steps[i];
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic longint remove_gain(input longint m);
      longint unsigned u, hi, lo;
      u = m;
      hi = u >> 30;
      lo = u & 64'h3FFF_FFFF;
      return longint'(hi * GAIN_Q30 + ((lo * GAIN_Q30) >> 30));
   endfunction

   function automatic logic [15:0] to_binary_angle(input longint z);
      longint r;
      r = (z + 64'sd32768) >>> 16;
      return r[15:0];
   endfunction

   function automatic angles_type compass_angles(input sample_type s);
      angles_type r;
      longint ax, ay, az, mx, my, mz, mg, syz, sxz, alpha, beta;
      longint ca, sa, cb, sb, xh, yh, heading;
      ax = longint'($signed(s.ax)); ay = longint'($signed(s.ay));
      az = longint'($signed(s.az));
      mx = longint'($signed(s.mx)); my = longint'($signed(s.my));
      mz = longint'($signed(s.mz));
      r = '0;
      if ((ax == 0 && ay == 0 && az == 0) || (mx == 0 && my == 0 && mz == 0)) begin
         r.degenerate = 1'b1;
         return r;
      end
      ax = ax <<< PRESHIFT;
      ay = ay <<< PRESHIFT;
      az = az <<< PRESHIFT;
      void'(vector_angle(az, ay, mg));
      syz = remove_gain(mg);
      alpha = vector_angle(syz, ax, mg);
      void'(vector_angle(az, ax, mg));
      sxz = remove_gain(mg);
      beta = vector_angle(sxz, ay, mg);
      sin_cos(alpha, ca, sa);
      sin_cos(beta, cb, sb);
      xh = mx * cb + my * ((sb * sa) >>> 28) + mz * ((sb * ca) >>> 28);
      yh = my * ca + mz * sa;
      heading = 0;
      if (xh != 0 || yh != 0)
         heading = vector_angle(xh, -yh, mg);
      r.pitch = to_binary_angle(alpha);
      r.roll = to_binary_angle(beta);
      r.heading = to_binary_angle(heading);
      return r;
   endfunction

   task automatic send_sample(input sample_type s);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_accel_x <= s.ax; req_accel_y <= s.ay; req_accel_z <= s.az;
      req_mag_x <= s.mx; req_mag_y <= s.my; req_mag_z <= s.mz;
      req_accel_ok <= s.accel_ok; req_mag_ok <= s.mag_ok;
      do @(posedge clock); while (req_stall);
      if (s.accel_ok && s.mag_ok)
         store_expected(compass_angles(s));
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      wait (expected_count == 0);
   endtask

   function automatic logic [15:0] random_axis();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               3: return 16'hFFFF;
               default: return 16'h0001;
            endcase
         1, 2: return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s.ax = random_axis(); s.ay = random_axis(); s.az = random_axis();
      s.mx = random_axis(); s.my = random_axis(); s.mz = random_axis();
      if ($urandom_range(0, 29) == 0) begin
         s.ax = '0; s.ay = '0; s.az = '0;
      end
      if ($urandom_range(0, 29) == 0) begin
         s.mx = '0; s.my = '0; s.mz = '0;
      end
      s.accel_ok = ($urandom_range(0, 9) != 0);
      s.mag_ok = ($urandom_range(0, 9) != 0);
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
      errors++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_phase == 0) begin
            stall_phase = $urandom_range(5, 60);
            stall_mode = $urandom_range(0, 3);
         end
         stall_phase--;
         rsp_stall <= ($urandom_range(0, 99) < stall_mode * 25);
      end
   end

   always @(posedge clock) begin
      angles_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_count == 0) begin
            $display("%0t: word with no expectation pending", $realtime);
            errors++;
         end else begin
            want = fetch_expected();
            if (rsp_pitch_angle !== want.pitch)
               report_mismatch("pitch", rsp_pitch_angle, want.pitch);
            if (rsp_roll_angle !== want.roll)
               report_mismatch("roll", rsp_roll_angle, want.roll);
            if (rsp_heading_angle !== want.heading)
               report_mismatch("heading", rsp_heading_angle, want.heading);
            if (rsp_degenerate !== want.degenerate)
               report_mismatch("degenerate", 16'(rsp_degenerate), 16'(want.degenerate));
         end
      end
   end

   task automatic test_directed();
      sample_type s;
      s = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'h0300, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0100, 16'h0200, 16'h0300, 16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b1};
      send_sample(s);
      s.accel_ok = 1'b1; s.mag_ok = 1'b0;
      send_sample(s);
      s.accel_ok = 1'b0;
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0800, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h1000, 16'hF000, 16'h0000, 16'h0000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h1000, 16'h1000, 16'h0000, 16'h0000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h1000, 16'h0000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'hF000, 16'h0000, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h1000, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'hF000, 16'h0000, 16'h0100, 16'hFF00, 16'h0100, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'h0000, 16'h0000, 16'hF000, 16'hFF00, 16'h0100, 16'hFF00, 1'b1, 1'b1};
      send_sample(s);
      s = '{16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b1, 1'b1};
      send_sample(s);
      pause_until_drained();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++)
         send_sample(random_sample());
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      test_random(200);
      pause_until_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(450);
      test_backpressure();
      test_random(500);
      pause_until_drained();
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/tcc_pkg.sv
src/tcc_vector.sv
src/tcc_rotate.sv
src/tcc_project.sv
src/tilt_compensated_compass.sv
test/tilt_compensated_compass_tb.sv
